FILE: rtl/pixel_shade_tint_unit_defines.svh
// assertion macros shared by the pixel shade/tint rtl
// no dependencies; included by the files that carry assertions
`ifndef PIXEL_SHADE_TINT_UNIT_DEFINES_SVH
`define PIXEL_SHADE_TINT_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define PST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define PST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define PST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define PST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/pst_pkg.sv
// types, constants and helper functions for the pixel shade/tint unit
// no dependencies; used by all rtl files of the block
package pst_pkg;

	localparam int NUM_CH    = 3;
	localparam int CH_W      = 8;
	localparam int LUT_DEPTH = 256;
	localparam int LUT_AW    = $clog2(LUT_DEPTH);
	localparam int LIM_W     = 16;
	localparam int ACC_W     = 24;
	localparam int CFG_W     = 16;
	localparam int IDX_W     = 3;

	// floor(x/100) = (x * RECIP_100) >> RECIP_SHIFT for x below 2^23
	localparam logic [23:0] RECIP_100   = 24'd10737419;
	localparam int          RECIP_SHIFT = 30;

	typedef enum logic [1:0] {
		FMT_RGB555 = 2'd0,
		FMT_RGB565 = 2'd1,
		FMT_RGB24  = 2'd2,
		FMT_RGB32  = 2'd3
	} fmt_t;

	typedef enum logic [IDX_W-1:0] {
		REG_FORMAT = 3'd0,
		REG_SHADE  = 3'd1,
		REG_TINT_R = 3'd2,
		REG_TINT_G = 3'd3,
		REG_TINT_B = 3'd4
	} reg_idx_t;

	typedef struct packed {
		fmt_t              fmt;
		logic signed [7:0] shade;
		logic [LIM_W-1:0]  tint_r;
		logic [LIM_W-1:0]  tint_g;
		logic [LIM_W-1:0]  tint_b;
	} cfg_t;

	typedef struct packed {
		logic                         we;
		logic [LUT_AW-1:0]            addr;
		logic [NUM_CH-1:0][CH_W-1:0]  data;
	} lut_wr_t;

	// floor(t/65535) for t below 256*65535, one correction step
	function automatic logic [CH_W-1:0] div_full_scale(input logic [ACC_W-1:0] t);
		logic [7:0]  q0;
		logic [16:0] r;
		q0 = t[23:16];
		r  = {1'b0, t[15:0]} + {9'b0, q0};
		return (r >= 17'd65535) ? q0 + 8'd1 : q0;
	endfunction

	// field width of a channel (0 red, 1 green, 2 blue) in a format
	function automatic logic [3:0] chan_bits(input fmt_t fmt, input logic [1:0] ch);
		case (fmt)
			FMT_RGB555: return 4'd5;
			FMT_RGB565: return (ch == 2'd1) ? 4'd6 : 4'd5;
			default:    return 4'd8;
		endcase
	endfunction

endpackage

FILE: rtl/pst_lut_ram.sv
// one channel lookup table: 256 x 8, one write port, one registered read port
// depends on pst_pkg
module pst_lut_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [pst_pkg::LUT_AW-1:0]   waddr,
	input  logic [pst_pkg::CH_W-1:0]     wdata,
	input  logic                         re,
	input  logic [pst_pkg::LUT_AW-1:0]   raddr,
	output logic [pst_pkg::CH_W-1:0]     rdata
);

	logic [pst_pkg::CH_W-1:0] mem [pst_pkg::LUT_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/pst_lut_builder.sv
// table builder: works out per-channel limits from shade and tint, then sweeps
// all entries of the three channel tables; depends on pst_pkg and the defines header
`include "pixel_shade_tint_unit_defines.svh"

module pst_lut_builder (
	input  logic             clk,
	input  logic             arst_n,
	input  pst_pkg::cfg_t    cfg,
	input  logic             restart,
	output logic             busy,
	output pst_pkg::lut_wr_t lut_wr
);

	typedef enum logic [2:0] {
		S_LIM_MUL,
		S_LIM_DIV,
		S_LIM_SET,
		S_INIT,
		S_SWEEP,
		S_IDLE
	} state_t;

	state_t                                              state_q;
	logic [1:0]                                          ch_q;
	logic [22:0]                                         prod_q;
	logic [pst_pkg::LIM_W-1:0]                           quot_q;
	logic [pst_pkg::NUM_CH-1:0][pst_pkg::LIM_W-1:0]      lo_q;
	logic [pst_pkg::NUM_CH-1:0][pst_pkg::LIM_W-1:0]      hi_q;
	logic [pst_pkg::NUM_CH-1:0][pst_pkg::ACC_W-1:0]      acc_q;
	logic [pst_pkg::LUT_AW-1:0]                          addr_q;

	logic signed [7:0]          shade_c;
	logic                       neg;
	logic [6:0]                 mag;
	logic [pst_pkg::LIM_W-1:0]  tint_sel;
	logic [pst_pkg::LIM_W-1:0]  base;
	logic [46:0]                recip_prod;

	always_comb begin
		if (cfg.shade < -8'sd100) begin
			shade_c = -8'sd100;
		end else if (cfg.shade > 8'sd100) begin
			shade_c = 8'sd100;
		end else begin
			shade_c = cfg.shade;
		end
		neg = shade_c[7];
		mag = neg ? 7'(-shade_c) : 7'(shade_c);
		// packed 24-bit swaps the red and blue limits
		case (ch_q)
			2'd0:    tint_sel = (cfg.fmt == pst_pkg::FMT_RGB24) ? cfg.tint_b : cfg.tint_r;
			2'd1:    tint_sel = cfg.tint_g;
			default: tint_sel = (cfg.fmt == pst_pkg::FMT_RGB24) ? cfg.tint_r : cfg.tint_b;
		endcase
		base       = neg ? ~tint_sel : tint_sel;
		recip_prod = {24'b0, prod_q} * {23'b0, pst_pkg::RECIP_100};
	end

	always_comb begin
		lut_wr.we   = (state_q == S_SWEEP);
		lut_wr.addr = addr_q;
		for (int c = 0; c < pst_pkg::NUM_CH; c++) begin
			lut_wr.data[c] = pst_pkg::div_full_scale(acc_q[c]);
		end
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LIM_MUL;
			ch_q    <= 2'd0;
			addr_q  <= '0;
		end else if (restart) begin
			state_q <= S_LIM_MUL;
			ch_q    <= 2'd0;
		end else begin
			case (state_q)
				S_LIM_MUL: begin
					prod_q  <= 23'({7'b0, base} * {16'b0, mag});
					state_q <= S_LIM_DIV;
				end
				S_LIM_DIV: begin
					quot_q  <= recip_prod[pst_pkg::RECIP_SHIFT+pst_pkg::LIM_W-1:pst_pkg::RECIP_SHIFT];
					state_q <= S_LIM_SET;
				end
				S_LIM_SET: begin
					if (neg) begin
						lo_q[ch_q] <= ~quot_q;
						hi_q[ch_q] <= '1;
					end else begin
						lo_q[ch_q] <= '0;
						hi_q[ch_q] <= quot_q;
					end
					if (ch_q == 2'(pst_pkg::NUM_CH - 1)) begin
						state_q <= S_INIT;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= S_LIM_MUL;
					end
				end
				S_INIT: begin
					// entry zero holds max*lower, max = 2^bits - 1
					for (int c = 0; c < pst_pkg::NUM_CH; c++) begin
						acc_q[c] <= ({8'b0, lo_q[c]} << pst_pkg::chan_bits(cfg.fmt, 2'(c)))
							- {8'b0, lo_q[c]};
					end
					addr_q  <= '0;
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					for (int c = 0; c < pst_pkg::NUM_CH; c++) begin
						acc_q[c] <= acc_q[c] + {8'b0, hi_q[c] - lo_q[c]};
					end
					addr_q <= addr_q + 1'b1;
					if (addr_q == pst_pkg::LUT_AW'(pst_pkg::LUT_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PST_ASSERT_NEXT(a_restart_clean, clk, arst_n, restart, state_q == S_LIM_MUL && ch_q == 2'd0, "restart did not reset the sequencer")
	`PST_ASSERT_IMPL(a_limits_order, clk, arst_n, state_q == S_SWEEP, lo_q[0] <= hi_q[0] && lo_q[1] <= hi_q[1] && lo_q[2] <= hi_q[2], "lower limit above upper limit")
	`PST_ASSERT_IMPL(a_sweep_step, clk, arst_n, state_q == S_SWEEP && $past(state_q == S_SWEEP) && !$past(restart), addr_q == pst_pkg::LUT_AW'($past(addr_q) + 1'b1), "sweep address skipped")

endmodule

FILE: rtl/pixel_shade_tint_unit.sv
// top level of the pixel shade/tint unit: config registers, table builder,
// three channel tables and the pixel read pipeline; depends on pst_pkg and the defines header
//
// Each pixel goes through three lookup tables, one per color channel, that hold
// the shaded and tinted value of every channel code. The unit takes one item per
// clock while busy is low; the result appears on pixel_out with done high for
// exactly one cycle, after the registered table read and the output register that
// holds the repacked pixel. The receiver cannot hold results off, and none is
// needed: the read pipeline never stalls. After reset, and after every
// configuration write, busy stays high while the tables are rebuilt: the lower
// and upper limits of the three channels are worked out first (a multiply and a
// multiply by the reciprocal of 100 for each), then the accumulators are seeded,
// then one table entry is written per cycle over all 256 entries. Start is
// ignored while busy is high; configuration writes are taken at any time and
// restart the rebuild.
`include "pixel_shade_tint_unit_defines.svh"

module pixel_shade_tint_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// item channel
	input  logic                        start,
	output logic                        busy,
	input  logic [31:0]                 pixel_in,
	// result channel
	output logic                        done,
	output logic [31:0]                 pixel_out,
	// configuration write port
	input  logic                        cfg_we,
	input  logic [pst_pkg::IDX_W-1:0]   cfg_index,
	input  logic [pst_pkg::CFG_W-1:0]   cfg_data
);

	pst_pkg::cfg_t    cfg_q;
	pst_pkg::lut_wr_t lut_wr;

	logic                                           accept;
	logic [pst_pkg::NUM_CH-1:0][pst_pkg::LUT_AW-1:0] raddr;
	logic [pst_pkg::NUM_CH-1:0][pst_pkg::CH_W-1:0]   rdata;

	logic          valid_s1;
	pst_pkg::fmt_t fmt_s1;
	logic [7:0]    top_s1;

	logic [31:0] packed_px;
	logic        done_q;
	logic [31:0] pixel_out_q;

	assign accept = start && !busy;

	// configuration registers, any write restarts the table rebuild
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fmt    <= pst_pkg::FMT_RGB32;
			cfg_q.shade  <= 8'sd100;
			cfg_q.tint_r <= '1;
			cfg_q.tint_g <= '1;
			cfg_q.tint_b <= '1;
		end else if (cfg_we) begin
			case (pst_pkg::reg_idx_t'(cfg_index))
				pst_pkg::REG_FORMAT: cfg_q.fmt    <= pst_pkg::fmt_t'(cfg_data[1:0]);
				pst_pkg::REG_SHADE:  cfg_q.shade  <= cfg_data[7:0];
				pst_pkg::REG_TINT_R: cfg_q.tint_r <= cfg_data;
				pst_pkg::REG_TINT_G: cfg_q.tint_g <= cfg_data;
				pst_pkg::REG_TINT_B: cfg_q.tint_b <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pst_lut_builder u_builder (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.restart (cfg_we),
		.busy    (busy),
		.lut_wr  (lut_wr)
	);

	// split the pixel into channel codes, these index the tables directly
	always_comb begin
		case (cfg_q.fmt)
			pst_pkg::FMT_RGB555: begin
				raddr[0] = {3'b0, pixel_in[14:10]};
				raddr[1] = {3'b0, pixel_in[9:5]};
				raddr[2] = {3'b0, pixel_in[4:0]};
			end
			pst_pkg::FMT_RGB565: begin
				raddr[0] = {3'b0, pixel_in[15:11]};
				raddr[1] = {2'b0, pixel_in[10:5]};
				raddr[2] = {3'b0, pixel_in[4:0]};
			end
			default: begin
				raddr[0] = pixel_in[23:16];
				raddr[1] = pixel_in[15:8];
				raddr[2] = pixel_in[7:0];
			end
		endcase
	end

	for (genvar c = 0; c < pst_pkg::NUM_CH; c++) begin : g_lut
		pst_lut_ram u_ram (
			.clk   (clk),
			.we    (lut_wr.we),
			.waddr (lut_wr.addr),
			.wdata (lut_wr.data[c]),
			.re    (accept),
			.raddr (raddr[c]),
			.rdata (rdata[c])
		);
	end

	// stage 1: table data arrives, carry format and top byte alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fmt_s1 <= cfg_q.fmt;
			top_s1 <= pixel_in[31:24];
		end
	end

	// repack, mapped codes never exceed the field maximum
	always_comb begin
		case (fmt_s1)
			pst_pkg::FMT_RGB555: packed_px = {17'b0, rdata[0][4:0], rdata[1][4:0], rdata[2][4:0]};
			pst_pkg::FMT_RGB565: packed_px = {16'b0, rdata[0][4:0], rdata[1][5:0], rdata[2][4:0]};
			pst_pkg::FMT_RGB24:  packed_px = {8'b0, rdata[0], rdata[1], rdata[2]};
			default:             packed_px = {top_s1, rdata[0], rdata[1], rdata[2]};
		endcase
	end

	// output register, strobe lasts one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			pixel_out_q <= packed_px;
		end
	end

	assign done      = done_q;
	assign pixel_out = pixel_out_q;

	`PST_ASSERT_IMPL(a_latency, clk, arst_n, accept, ##2 done, "result strobe missing two cycles after an item")
	`PST_ASSERT_IMPL(a_no_write_on_read, clk, arst_n, accept, !lut_wr.we, "table written while an item reads it")
	`PST_ASSERT_NEXT(a_cfg_rebuild, clk, arst_n, cfg_we, busy, "config write did not start a rebuild")

endmodule

FILE: tb/testbench.sv
// self-checking testbench for pixel_shade_tint_unit: directed and random pixel traffic
// checked against an in-bench shade/tint predictor; depends on pst_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
	import pst_pkg::*;

	// result passes the registered table read and then the output register
	localparam int RESULT_LATENCY = 2;
	// registers at or above this index are ignored by the block
	localparam int REG_COUNT      = 5;
	localparam int CYCLE_LIMIT    = 300000;
	localparam int RANDOM_PHASES  = 16;
	localparam int PHASE_ITEMS    = 50;
	localparam int FULL_SCALE     = 65535;
	localparam int PERCENT        = 100;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic [31:0]      pixel_in = '0;
	logic             done;
	logic [31:0]      pixel_out;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	pixel_shade_tint_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pixel_in  (pixel_in),
		.done      (done),
		.pixel_out (pixel_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// shadow copy of the configuration registers, reset values
	fmt_t              cur_fmt   = FMT_RGB32;
	logic signed [7:0] cur_shade = 8'sd100;
	logic [15:0]       cur_tint [3] = '{16'hffff, 16'hffff, 16'hffff};

	logic [31:0] expected_pixels [$];
	int          sender_idle_pct = 0;
	int          pixels_sent     = 0;
	int          pixels_checked  = 0;
	int          reg_writes      = 0;
	int          error_count     = 0;
	int          cycle_count     = 0;

	// lower/upper 16-bit limits of one channel for a clamped shade amount
	function automatic void channel_limits(input int tint, input int shade,
			output int lo, output int hi);
		if (shade < 0) begin
			lo = FULL_SCALE - ((FULL_SCALE - tint) * (-shade)) / PERCENT;
			hi = FULL_SCALE;
		end else begin
			lo = 0;
			hi = (tint * shade) / PERCENT;
		end
	endfunction

	// expected shaded pixel under the current shadow configuration
	function automatic logic [31:0] shade_pixel(input logic [31:0] px);
		int          shade;
		int          lo [3];
		int          hi [3];
		int          shift [3];
		int          maxv [3];
		int          t;
		longint      acc;
		logic [31:0] res;
		shade = cur_shade;
		if (shade < -PERCENT) shade = -PERCENT;
		if (shade > PERCENT)  shade = PERCENT;
		for (int c = 0; c < 3; c++)
			channel_limits(cur_tint[c], shade, lo[c], hi[c]);
		// packed 24-bit swaps the red and blue limits
		if (cur_fmt == FMT_RGB24) begin
			t = lo[0]; lo[0] = lo[2]; lo[2] = t;
			t = hi[0]; hi[0] = hi[2]; hi[2] = t;
		end
		case (cur_fmt)
			FMT_RGB555: begin
				shift = '{10, 5, 0};
				maxv  = '{31, 31, 31};
			end
			FMT_RGB565: begin
				shift = '{11, 5, 0};
				maxv  = '{31, 63, 31};
			end
			default: begin
				shift = '{16, 8, 0};
				maxv  = '{255, 255, 255};
			end
		endcase
		res = '0;
		for (int c = 0; c < 3; c++) begin
			acc = longint'((px >> shift[c]) & maxv[c]) * (hi[c] - lo[c])
				+ longint'(maxv[c]) * lo[c];
			res |= 32'(acc / FULL_SCALE) << shift[c];
		end
		// alpha byte passes straight through
		if (cur_fmt == FMT_RGB32)
			res[31:24] = px[31:24];
		return res;
	endfunction

	// one register write; shadow follows the same field masking as the block
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FORMAT: cur_fmt     = fmt_t'(data[1:0]);
			REG_SHADE:  cur_shade   = data[7:0];
			REG_TINT_R: cur_tint[0] = data;
			REG_TINT_G: cur_tint[1] = data;
			REG_TINT_B: cur_tint[2] = data;
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	// whole configuration; unused high bits of format and shade get noise
	task automatic set_config(input fmt_t fmt, input int shade,
			input int tr, input int tg, input int tb);
		write_reg(REG_FORMAT, ($urandom() & 16'hfffc) | fmt);
		write_reg(REG_SHADE, ($urandom() & 16'hff00) | (shade & 8'hff));
		write_reg(REG_TINT_R, tr[15:0]);
		write_reg(REG_TINT_G, tg[15:0]);
		write_reg(REG_TINT_B, tb[15:0]);
	endtask

	// offers one pixel and waits until the block takes it; start is left high so
	// a following item can go out on the next edge
	task automatic send_pixel(input logic [31:0] px);
		while ($urandom_range(99) < sender_idle_pct) begin
			start    <= 1'b0;
			pixel_in <= $urandom();
			@(posedge clk);
		end
		start    <= 1'b1;
		pixel_in <= px;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		expected_pixels.push_back(shade_pixel(px));
		pixels_sent++;
	endtask

	// stop sending and let every outstanding result come back
	task automatic wait_drained();
		start <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY) @(posedge clk);
	endtask

	// result checker: every strobe must match the oldest expectation
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && done === 1'b1) begin
			if (expected_pixels.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("ERROR: unexpected result %h", pixel_out);
			end else begin
				want = expected_pixels.pop_front();
				pixels_checked++;
				if (pixel_out !== want) begin
					error_count++;
					if (error_count <= 10)
						$display("ERROR: pixel_out expected %h got %h", want, pixel_out);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// reset values straight out of reset
	task automatic test_reset_defaults();
		send_pixel(32'h0000_0000);
		send_pixel(32'hffff_ffff);
		send_pixel(32'h5a3c_96e1);
		wait_drained();
	endtask

	// every format, with distinct tints so the 24-bit red/blue swap shows up;
	// all-ones pixels exercise the ignored high bits and the alpha byte
	task automatic test_formats();
		for (int f = 0; f < 4; f++) begin
			set_config(fmt_t'(f), 100, 16'hffff, 16'h8000, 16'h0000);
			send_pixel(32'hffff_ffff);
			send_pixel(32'hc3a5_5a7e);
			wait_drained();
		end
	endtask

	// shade extremes, zero shade and values beyond +-100 that clamp
	task automatic test_shade_range();
		int shades [6] = '{-128, -100, -1, 0, 1, 127};
		foreach (shades[i]) begin
			set_config(FMT_RGB32, shades[i], 16'h1234, 16'habcd, 16'h0000);
			send_pixel(32'h80ff_7f01);
			wait_drained();
		end
	endtask

	// writes above the last register must leave the configuration alone
	task automatic test_ignored_index();
		set_config(FMT_RGB565, -60, 16'h0f0f, 16'hffff, 16'h3000);
		for (int i = REG_COUNT; i < 2 ** IDX_W; i++)
			write_reg(IDX_W'(i), $urandom());
		send_pixel(32'hffff_ffff);
		send_pixel(32'h0000_a5a5);
		wait_drained();
	endtask

	function automatic int pick_shade();
		case ($urandom_range(9))
			0: return -100;
			1: return 100;
			2: return 0;
			3: return -$urandom_range(101, 128);
			4: return $urandom_range(101, 127);
			default: return int'($urandom_range(200)) - 100;
		endcase
	endfunction

	function automatic int pick_tint();
		case ($urandom_range(3))
			0: return 0;
			1: return FULL_SCALE;
			default: return $urandom_range(FULL_SCALE);
		endcase
	endfunction

	// phases of random pixels, each under a fresh configuration; sender gaps
	// go from moderate to heavy to none
	task automatic test_random_traffic();
		logic [31:0] px;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph < 6)
				sender_idle_pct = 32;
			else if (ph < 11)
				sender_idle_pct = 53;
			else
				sender_idle_pct = 0;
			set_config(fmt_t'($urandom_range(3)), pick_shade(),
				pick_tint(), pick_tint(), pick_tint());
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// now and then hold off until the pipe is empty
				if ($urandom_range(39) == 0)
					wait_drained();
				case ($urandom_range(15))
					0: px = '0;
					1: px = '1;
					default: px = $urandom();
				endcase
				send_pixel(px);
			end
			wait_drained();
		end
		sender_idle_pct = 0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_formats();
		test_shade_range();
		test_ignored_index();
		test_random_traffic();

		wait_drained();
		repeat (10) @(posedge clk);
		if (expected_pixels.size() != 0) begin
			error_count++;
			$display("ERROR: %0d results never arrived", expected_pixels.size());
		end
		$display("covered all four pixel formats, clamped and extreme shades, tint extremes");
		$display("%0d pixels sent, %0d checked, %0d register writes, %0d errors",
			pixels_sent, pixels_checked, reg_writes, error_count);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
